FILE: rtl/scalar_kalman_filter_defines.svh
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SKF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SKF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/skf_pkg.sv
// Shared types, constants and the micro-op table of the scalar Kalman filter.
package skf_pkg;

    localparam int DW     = 32;            // Q8.24 word width
    localparam int FB     = 24;            // fractional bits
    localparam int VAR_W  = 31;            // width of variance fields
    localparam int STEP_W = 5;             // micro-op step counter width
    localparam int CFG_W  = 3;             // configuration index width

    localparam logic [DW-1:0] QMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] QMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] Q_ONE = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

    localparam logic [VAR_W-1:0] RST_PROCESS_VAR = 31'd1678;
    localparam logic [VAR_W-1:0] RST_MEASURE_VAR = 31'd167772;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;

    typedef enum logic {
        ACT_UPDATE,
        ACT_RESTART
    } t_action;

    typedef enum logic [CFG_W-1:0] {
        CFG_STATE_GAIN,
        CFG_MEAS_GAIN,
        CFG_CONTROL_GAIN,
        CFG_PROCESS_VAR,
        CFG_MEASURE_VAR,
        CFG_INIT_EST,
        CFG_INIT_VAR
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MULWB,
        ST_DIVWAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_CHK,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        SRC_A, SRC_B, SRC_H, SRC_Q, SRC_R, SRC_ONE, SRC_X, SRC_P,
        SRC_U, SRC_Z, SRC_XP, SRC_PP, SRC_Y, SRC_G, SRC_T0, SRC_T1
    } t_src;

    typedef enum logic [2:0] {
        DST_T0, DST_T1, DST_XP, DST_PP, DST_Y, DST_X, DST_P, DST_G
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src sa;
        t_src sb;
        t_dst dst;
    } t_uop;

    // Saturated Q8.24 result with its clip flag.
    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } t_res;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] val;
        logic                 sat;
    } t_div_out;

    // Predict, innovate, divide, correct.
    function automatic t_uop skf_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:    u = '{OP_MUL, SRC_A,   SRC_X,  DST_T0};  // A*x
            5'd1:    u = '{OP_MUL, SRC_B,   SRC_U,  DST_T1};  // B*u
            5'd2:    u = '{OP_ADD, SRC_T0,  SRC_T1, DST_XP};  // x_pred
            5'd3:    u = '{OP_MUL, SRC_A,   SRC_P,  DST_T0};  // A*P
            5'd4:    u = '{OP_MUL, SRC_T0,  SRC_A,  DST_T0};  // (A*P)*A
            5'd5:    u = '{OP_ADD, SRC_T0,  SRC_Q,  DST_PP};  // P_pred
            5'd6:    u = '{OP_MUL, SRC_H,   SRC_XP, DST_T0};  // H*x_pred
            5'd7:    u = '{OP_SUB, SRC_Z,   SRC_T0, DST_Y};   // innovation
            5'd8:    u = '{OP_MUL, SRC_H,   SRC_PP, DST_T0};  // H*P_pred
            5'd9:    u = '{OP_MUL, SRC_T0,  SRC_H,  DST_T0};  // (H*P_pred)*H
            5'd10:   u = '{OP_ADD, SRC_T0,  SRC_R,  DST_T0};  // S
            5'd11:   u = '{OP_CHK, SRC_T0,  SRC_T0, DST_T0};  // S > 0 ?
            5'd12:   u = '{OP_MUL, SRC_PP,  SRC_H,  DST_T1};  // numerator
            5'd13:   u = '{OP_DIV, SRC_T1,  SRC_T0, DST_G};   // gain
            5'd14:   u = '{OP_MUL, SRC_G,   SRC_Y,  DST_T0};  // K*y
            5'd15:   u = '{OP_ADD, SRC_XP,  SRC_T0, DST_X};   // corrected x
            5'd16:   u = '{OP_MUL, SRC_G,   SRC_H,  DST_T0};  // K*H
            5'd17:   u = '{OP_SUB, SRC_ONE, SRC_T0, DST_T0};  // 1 - K*H
            5'd18:   u = '{OP_MUL, SRC_T0,  SRC_PP, DST_P};   // corrected P
            default: u = '{OP_CHK, SRC_T0,  SRC_T0, DST_T0};
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/skf_alu.sv
// Shared saturating Q8.24 multiply and add/subtract unit.
module skf_alu (
    input  logic                         i_clk,
    input  logic                         i_mul_en,
    input  logic                         i_sub,
    input  logic signed [skf_pkg::DW-1:0] i_a,
    input  logic signed [skf_pkg::DW-1:0] i_b,
    output skf_pkg::t_res                o_add,
    output skf_pkg::t_res                o_mul
);

    localparam int DW     = skf_pkg::DW;
    localparam int FB     = skf_pkg::FB;
    localparam int PROD_W = 2 * DW;
    localparam int SH_W   = PROD_W - FB;

    logic signed [PROD_W-1:0] r_prod;
    logic        [SH_W-1:0]   sh_t;
    logic                     corr;
    logic                     mul_fit;
    logic        [DW:0]       sum;
    logic                     add_fit;

    // Register the full product before scaling.
    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    // Truncate toward zero: floor shift, plus one for negative inexact products.
    always_comb begin
        corr    = r_prod[PROD_W-1] && (r_prod[FB-1:0] != '0);
        sh_t    = r_prod[PROD_W-1:FB] + SH_W'(corr);
        mul_fit = (&sh_t[SH_W-1:DW-1]) || !(|sh_t[SH_W-1:DW-1]);
        o_mul.sat = !mul_fit;
        o_mul.val = mul_fit ? sh_t[DW-1:0] : (sh_t[SH_W-1] ? skf_pkg::QMIN : skf_pkg::QMAX);
    end

    always_comb begin
        if (i_sub) begin
            sum = {i_a[DW-1], i_a} - {i_b[DW-1], i_b};
        end else begin
            sum = {i_a[DW-1], i_a} + {i_b[DW-1], i_b};
        end
        add_fit   = (sum[DW] == sum[DW-1]);
        o_add.sat = !add_fit;
        o_add.val = add_fit ? sum[DW-1:0] : (sum[DW] ? skf_pkg::QMIN : skf_pkg::QMAX);
    end

endmodule

FILE: rtl/skf_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle.
`include "scalar_kalman_filter_defines.svh"

module skf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [skf_pkg::DW-1:0] i_num,
    input  logic signed [skf_pkg::DW-1:0] i_den,   // known positive
    output skf_pkg::t_div_out             o_out
);

    localparam int DW    = skf_pkg::DW;
    localparam int FB    = skf_pkg::FB;
    localparam int HI_SH = DW - FB;
    localparam int CMP_W = DW + HI_SH;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_neg;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_work;
    logic [DW-1:0]    r_den;

    logic [DW-1:0]    num_u;
    logic [DW-1:0]    num_mag;
    logic             ovf;
    logic [DW:0]      rem_sh;
    logic             ge;
    logic [DW:0]      rem_df;

    always_comb begin
        num_u   = i_num;
        num_mag = i_num[DW-1] ? (~num_u + DW'(1)) : num_u;
        // Quotient of (|num| << FB) / den reaches 2^DW exactly when this holds.
        ovf     = CMP_W'(num_mag) >= {i_den, {HI_SH{1'b0}}};
        rem_sh  = {r_rem, r_work[DW-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_df  = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf  <= ovf;
            r_neg  <= i_num[DW-1];
            r_den  <= i_den;
            r_rem  <= DW'(num_mag >> HI_SH);
            r_work <= {num_mag[HI_SH-1:0], {FB{1'b0}}};
        end else if (r_busy) begin
            r_rem  <= ge ? rem_df[DW-1:0] : rem_sh[DW-1:0];
            r_work <= {r_work[DW-2:0], ge};
        end
    end

    // Apply sign and clip to the Q8.24 range.
    always_comb begin
        o_out.done = r_done;
        if (r_ovf) begin
            o_out.sat = 1'b1;
            o_out.val = r_neg ? skf_pkg::QMIN : skf_pkg::QMAX;
        end else if (r_neg) begin
            o_out.sat = r_work[DW-1] && (r_work[DW-2:0] != '0);
            o_out.val = o_out.sat ? skf_pkg::QMIN : (~r_work + DW'(1));
        end else begin
            o_out.sat = r_work[DW-1];
            o_out.val = r_work[DW-1] ? skf_pkg::QMAX : r_work;
        end
    end

    `SKF_ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_busy, r_rem < r_den, "divider remainder not below divisor")

endmodule

FILE: rtl/scalar_kalman_filter.sv
// Top level of the one-dimensional Q8.24 Kalman filter: sequencer, registers, channels.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: measurement, control_in
//                                                    tuser: action
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: estimate, variance, gain
//                                                    tuser: zero_divisor, saturated
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
//  An update item runs eleven products in the shared multiplier, six add/subtract
//  steps, a sign check and the restoring divider (one quotient bit per cycle). A
//  gain that overflows skips the division loop; a non-positive innovation variance
//  ends the item at the check step; a restart item goes straight to its result.
//  Reset is synchronous and active low; it loads the register defaults and the
//  initial estimate and variance. s_axis_tready is high only while the sequencer
//  is idle; a finished result waits in the output register while the next item is
//  taken, and the sequencer stalls before its result write if that register is full.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] measurement, [63:32] control_in
    input  logic [0:0]  s_axis_tuser,   // [0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] estimate_out, [62:32] variance_out,
                                        // [94:63] gain_out, [95] zero
    output logic [1:0]  m_axis_tuser,   // [0] zero_divisor, [1] saturated
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int DW    = skf_pkg::DW;
    localparam int VAR_W = skf_pkg::VAR_W;
    localparam int STEP_W = skf_pkg::STEP_W;

    // configuration registers
    logic signed [DW-1:0]    r_a, r_h, r_b, r_x0;
    logic        [VAR_W-1:0] r_q, r_r, r_p0;

    // filter state and per-item flags
    logic signed [DW-1:0]    r_x;
    logic        [VAR_W-1:0] r_p;
    logic signed [DW-1:0]    r_g;
    logic                    r_zdiv;
    logic                    r_sat;

    // working registers
    logic signed [DW-1:0]    r_z, r_u, r_xp, r_pp, r_y, r_t0, r_t1;

    // sequencer
    skf_pkg::t_state         r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    skf_pkg::t_uop           uop;

    // output register
    logic                    r_ovalid, n_ovalid;
    logic signed [DW-1:0]    r_oest, r_ogain;
    logic        [VAR_W-1:0] r_ovar;
    logic                    r_ozdiv, r_osat;

    logic                    in_acc;
    logic                    restart;
    logic signed [DW-1:0]    op_a, op_b;
    logic                    mul_en;
    logic                    div_start;
    logic                    wr_en;
    logic signed [DW-1:0]    wr_val;
    logic                    wr_sat;
    logic                    set_zdiv;
    logic                    out_load;
    logic                    s_nonpos;
    skf_pkg::t_res           add_res, mul_res;
    skf_pkg::t_div_out       div_out;

    assign s_axis_tready = (r_state == skf_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign restart       = (s_axis_tuser[0] == skf_pkg::ACT_RESTART);
    assign o_cfg_ready   = 1'b1;
    assign uop           = skf_pkg::skf_uop(r_step);
    assign s_nonpos      = r_t0[DW-1] || (r_t0 == '0);

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ogain, r_ovar, r_oest};
    assign m_axis_tuser  = {r_osat, r_ozdiv};

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a  <= skf_pkg::Q_ONE;
            r_h  <= skf_pkg::Q_ONE;
            r_b  <= '0;
            r_q  <= skf_pkg::RST_PROCESS_VAR;
            r_r  <= skf_pkg::RST_MEASURE_VAR;
            r_x0 <= '0;
            r_p0 <= skf_pkg::Q_ONE[VAR_W-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (skf_pkg::t_cfg_idx'(i_cfg_index))
                skf_pkg::CFG_STATE_GAIN:   r_a  <= i_cfg_data;
                skf_pkg::CFG_MEAS_GAIN:    r_h  <= i_cfg_data;
                skf_pkg::CFG_CONTROL_GAIN: r_b  <= i_cfg_data;
                skf_pkg::CFG_PROCESS_VAR:  r_q  <= i_cfg_data[VAR_W-1:0];
                skf_pkg::CFG_MEASURE_VAR:  r_r  <= i_cfg_data[VAR_W-1:0];
                skf_pkg::CFG_INIT_EST:     r_x0 <= i_cfg_data;
                skf_pkg::CFG_INIT_VAR:     r_p0 <= i_cfg_data[VAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand selection for the shared unit.
    always_comb begin
        case (uop.sa)
            skf_pkg::SRC_A:   op_a = r_a;
            skf_pkg::SRC_B:   op_a = r_b;
            skf_pkg::SRC_H:   op_a = r_h;
            skf_pkg::SRC_Q:   op_a = {1'b0, r_q};
            skf_pkg::SRC_R:   op_a = {1'b0, r_r};
            skf_pkg::SRC_ONE: op_a = skf_pkg::Q_ONE;
            skf_pkg::SRC_X:   op_a = r_x;
            skf_pkg::SRC_P:   op_a = {1'b0, r_p};
            skf_pkg::SRC_U:   op_a = r_u;
            skf_pkg::SRC_Z:   op_a = r_z;
            skf_pkg::SRC_XP:  op_a = r_xp;
            skf_pkg::SRC_PP:  op_a = r_pp;
            skf_pkg::SRC_Y:   op_a = r_y;
            skf_pkg::SRC_G:   op_a = r_g;
            skf_pkg::SRC_T0:  op_a = r_t0;
            skf_pkg::SRC_T1:  op_a = r_t1;
            default:          op_a = r_t0;
        endcase
    end

    always_comb begin
        case (uop.sb)
            skf_pkg::SRC_A:   op_b = r_a;
            skf_pkg::SRC_B:   op_b = r_b;
            skf_pkg::SRC_H:   op_b = r_h;
            skf_pkg::SRC_Q:   op_b = {1'b0, r_q};
            skf_pkg::SRC_R:   op_b = {1'b0, r_r};
            skf_pkg::SRC_ONE: op_b = skf_pkg::Q_ONE;
            skf_pkg::SRC_X:   op_b = r_x;
            skf_pkg::SRC_P:   op_b = {1'b0, r_p};
            skf_pkg::SRC_U:   op_b = r_u;
            skf_pkg::SRC_Z:   op_b = r_z;
            skf_pkg::SRC_XP:  op_b = r_xp;
            skf_pkg::SRC_PP:  op_b = r_pp;
            skf_pkg::SRC_Y:   op_b = r_y;
            skf_pkg::SRC_G:   op_b = r_g;
            skf_pkg::SRC_T0:  op_b = r_t0;
            skf_pkg::SRC_T1:  op_b = r_t1;
            default:          op_b = r_t0;
        endcase
    end

    skf_alu u_alu (
        .i_clk    (i_clk),
        .i_mul_en (mul_en),
        .i_sub    (uop.op == skf_pkg::OP_SUB),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_add    (add_res),
        .o_mul    (mul_res)
    );

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (op_a),
        .i_den   (op_b),
        .o_out   (div_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= skf_pkg::ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    // Sequencer: issue one micro-op, write its result, advance the step.
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        mul_en    = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        wr_val    = add_res.val;
        wr_sat    = 1'b0;
        set_zdiv  = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            skf_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_step  = '0;
                    n_state = restart ? skf_pkg::ST_DONE : skf_pkg::ST_ISSUE;
                end
            end
            skf_pkg::ST_ISSUE: begin
                case (uop.op)
                    skf_pkg::OP_MUL: begin
                        mul_en  = 1'b1;
                        n_state = skf_pkg::ST_MULWB;
                    end
                    skf_pkg::OP_ADD, skf_pkg::OP_SUB: begin
                        wr_en  = 1'b1;
                        wr_val = add_res.val;
                        wr_sat = add_res.sat;
                    end
                    skf_pkg::OP_CHK: begin
                        // Innovation variance not positive: keep the prediction.
                        if (s_nonpos) begin
                            set_zdiv = 1'b1;
                            n_state  = skf_pkg::ST_DONE;
                        end else begin
                            n_step = r_step + STEP_W'(1);
                        end
                    end
                    skf_pkg::OP_DIV: begin
                        div_start = 1'b1;
                        n_state   = skf_pkg::ST_DIVWAIT;
                    end
                    default: n_state = skf_pkg::ST_DONE;
                endcase
            end
            skf_pkg::ST_MULWB: begin
                wr_en  = 1'b1;
                wr_val = mul_res.val;
                wr_sat = mul_res.sat;
            end
            skf_pkg::ST_DIVWAIT: begin
                if (div_out.done) begin
                    wr_en  = 1'b1;
                    wr_val = div_out.val;
                    wr_sat = div_out.sat;
                end
            end
            skf_pkg::ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = skf_pkg::ST_IDLE;
                end
            end
            default: n_state = skf_pkg::ST_IDLE;
        endcase

        // Advance after every result write; the last step finishes the item.
        if (wr_en) begin
            if (r_step == skf_pkg::LAST_STEP) begin
                n_state = skf_pkg::ST_DONE;
            end else begin
                n_step  = r_step + STEP_W'(1);
                n_state = skf_pkg::ST_ISSUE;
            end
        end

        n_ovalid = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : r_ovalid);
    end

    // Filter state and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_p    <= skf_pkg::Q_ONE[VAR_W-1:0];
            r_g    <= '0;
            r_zdiv <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_g    <= '0;
                r_zdiv <= 1'b0;
                r_sat  <= 1'b0;
                if (restart) begin
                    r_x <= r_x0;
                    r_p <= r_p0;
                end
            end
            if (wr_en) begin
                if (wr_sat) begin
                    r_sat <= 1'b1;
                end
                case (uop.dst)
                    skf_pkg::DST_X: r_x <= wr_val;
                    skf_pkg::DST_G: r_g <= wr_val;
                    skf_pkg::DST_P: begin
                        // Clamp a negative corrected variance to zero and flag it.
                        if (wr_val[DW-1]) begin
                            r_p   <= '0;
                            r_sat <= 1'b1;
                        end else begin
                            r_p <= wr_val[VAR_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (set_zdiv) begin
                r_zdiv <= 1'b1;
                r_x    <= r_xp;
                r_p    <= r_pp[DW-1] ? '0 : r_pp[VAR_W-1:0];
            end
        end
    end

    // Working registers: input latch and intermediate results.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_z <= s_axis_tdata[DW-1:0];
            r_u <= s_axis_tdata[2*DW-1:DW];
        end
        if (wr_en) begin
            case (uop.dst)
                skf_pkg::DST_T0: r_t0 <= wr_val;
                skf_pkg::DST_T1: r_t1 <= wr_val;
                skf_pkg::DST_XP: r_xp <= wr_val;
                skf_pkg::DST_PP: r_pp <= wr_val;
                skf_pkg::DST_Y:  r_y  <= wr_val;
                default: ;
            endcase
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oest  <= r_x;
            r_ovar  <= r_p;
            r_ogain <= r_g;
            r_ozdiv <= r_zdiv;
            r_osat  <= r_sat;
        end
    end

    `SKF_ASSERT_NXT(a_update_starts, i_clk, i_rst_n, in_acc && !restart, (r_state == skf_pkg::ST_ISSUE) && (r_step == '0), "update item did not start at step zero")
    `SKF_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, div_out.done, r_state == skf_pkg::ST_DIVWAIT, "divider finished outside its wait state")
    `SKF_ASSERT_IMP(a_zdiv_no_gain, i_clk, i_rst_n, r_ovalid && r_ozdiv, r_ogain == '0, "nonzero gain reported with zero divisor")

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the scalar Q8.24 Kalman filter stream block.
`timescale 1ns / 100ps

module testbench;
    import skf_pkg::*;

    // Register index that the block does not decode; writes to it must be dropped.
    localparam logic [CFG_W-1:0] CFG_NONE = 3'd7;

    localparam longint UNITY  = longint'(1) <<< FB;
    localparam longint SAT_HI = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // Stimulus flavors of the random phases.
    localparam int MODE_TRACK   = 0;   // plausible gains, measurements near the estimate
    localparam int MODE_WILD    = 1;   // every word fully random
    localparam int MODE_EXTREME = 2;   // corner words everywhere
    localparam int MODE_DEGEN   = 3;   // no measurement noise, tiny or zero H

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int MAX_REPORTS  = 40;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic signed [DW-1:0]  estimate;
        logic [VAR_W-1:0]      variance;
        logic signed [DW-1:0]  gain;
        logic                  zero_div;
        logic                  clipped;
    } kf_result_t;

    typedef struct {
        longint state_gain, meas_gain, ctrl_gain, proc_var, meas_var, init_est, init_var;
    } kf_regs_t;

    typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_e;

    typedef struct {
        row_kind_e        kind;
        logic [CFG_W-1:0] idx;
        logic [31:0]      data;
        t_action          act;
        logic [31:0]      z;
        logic [31:0]      u;
        bit               typed;
        kf_result_t       want;
    } plan_row_t;

    // DUT connections; every input starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    // Filter state mirrored by the predictor.
    kf_regs_t   filt_regs;
    longint     est_q;
    longint     cov_q;
    bit         clip_seen;

    kf_result_t pending_updates[$];
    plan_row_t  directed_rows[$];
    int         fail_count   = 0;
    int         results_seen = 0;
    int         burst_left   = 0;

    // Receiver stall state.
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    logic [7:0]  stall_tick  = '0;
    int          stall_style = 0;

    kf_result_t seen_r;
    kf_result_t want_r;

    int phase_mode[PHASES] = '{MODE_TRACK, MODE_WILD, MODE_TRACK, MODE_EXTREME,
                               MODE_TRACK, MODE_DEGEN, MODE_TRACK, MODE_EXTREME};

    scalar_kalman_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Saturate to the signed word range and note the clip.
    function automatic longint clamp_q(input longint v);
        if (v > SAT_HI) begin
            clip_seen = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            clip_seen = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // Fixed-point product, truncated toward zero.
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp_q((p < 0) ? -((-p) >>> FB) : (p >>> FB));
    endfunction

    function automatic void apply_reg_write(input logic [CFG_W-1:0] idx,
                                            input logic [31:0] d);
        case (idx)
            CFG_STATE_GAIN:   filt_regs.state_gain = signed'(d);
            CFG_MEAS_GAIN:    filt_regs.meas_gain  = signed'(d);
            CFG_CONTROL_GAIN: filt_regs.ctrl_gain  = signed'(d);
            CFG_PROCESS_VAR:  filt_regs.proc_var   = longint'(d[VAR_W-1:0]);
            CFG_MEASURE_VAR:  filt_regs.meas_var   = longint'(d[VAR_W-1:0]);
            CFG_INIT_EST:     filt_regs.init_est   = signed'(d);
            CFG_INIT_VAR:     filt_regs.init_var   = longint'(d[VAR_W-1:0]);
            default: ;   // undecoded index: drop the write
        endcase
    endfunction

    // Advance the mirrored filter by one sample and return the result it produces.
    function automatic kf_result_t kalman_step(input t_action act, input logic [31:0] z,
                                               input logic [31:0] u);
        kf_result_t r;
        longint     zz, uu, xp, pp, y, s, num, k, pv;
        clip_seen  = 1'b0;
        k          = 0;
        r.zero_div = 1'b0;
        if (act == ACT_RESTART) begin
            est_q = filt_regs.init_est;
            cov_q = filt_regs.init_var;
        end else begin
            zz = longint'(signed'(z));
            uu = longint'(signed'(u));
            // predict
            xp = clamp_q(fx_mul(filt_regs.state_gain, est_q) + fx_mul(filt_regs.ctrl_gain, uu));
            pp = clamp_q(fx_mul(fx_mul(filt_regs.state_gain, cov_q), filt_regs.state_gain)
                         + filt_regs.proc_var);
            // innovation and its variance
            y  = clamp_q(zz - fx_mul(filt_regs.meas_gain, xp));
            s  = clamp_q(fx_mul(fx_mul(filt_regs.meas_gain, pp), filt_regs.meas_gain)
                         + filt_regs.meas_var);
            if (s <= 0) begin
                // no usable divisor: keep the prediction, report zero gain
                r.zero_div = 1'b1;
                est_q      = xp;
                cov_q      = (pp < 0) ? 0 : pp;
            end else begin
                num   = fx_mul(pp, filt_regs.meas_gain);
                k     = clamp_q((num * UNITY) / s);
                est_q = clamp_q(xp + fx_mul(k, y));
                pv    = fx_mul(clamp_q(UNITY - fx_mul(k, filt_regs.meas_gain)), pp);
                // truncation can push the corrected variance below zero
                if (pv < 0) begin
                    clip_seen = 1'b1;
                    pv        = 0;
                end
                cov_q = pv;
            end
        end
        r.estimate = est_q[DW-1:0];
        r.variance = cov_q[VAR_W-1:0];
        r.gain     = k[DW-1:0];
        r.clipped  = clip_seen;
        return r;
    endfunction

    // ------------------------------------------------------------ value helpers

    function automatic logic [31:0] around(input longint centre, input longint spread);
        return 32'(centre - spread + longint'($urandom_range(0, 2 * spread)));
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return QMIN;
            1:       return QMAX;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            default: return 32'd1;
        endcase
    endfunction

    // ------------------------------------------------------------ directed plan

    function automatic void add_reg(input logic [CFG_W-1:0] idx, input logic [31:0] data);
        plan_row_t r;
        r = '{kind: ROW_REG, idx: idx, data: data, act: ACT_UPDATE, z: '0, u: '0,
              typed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_sample(input t_action act, input logic [31:0] z,
                                       input logic [31:0] u);
        plan_row_t r;
        r = '{kind: ROW_SAMPLE, idx: '0, data: '0, act: act, z: z, u: u,
              typed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    // A restart reloads the initial registers and reports no gain and no flags.
    function automatic void add_restart_checked(input logic [31:0] est,
                                                input logic [VAR_W-1:0] cov);
        plan_row_t r;
        r = '{kind: ROW_SAMPLE, idx: '0, data: '0, act: ACT_RESTART, z: $urandom(),
              u: $urandom(), typed: 1'b1,
              want: '{estimate: est, variance: cov, gain: '0, zero_div: 1'b0,
                      clipped: 1'b0}};
        directed_rows.push_back(r);
    endfunction

    function automatic void build_directed_plan();
        // reset defaults
        add_restart_checked('0, Q_ONE[VAR_W-1:0]);
        add_sample(ACT_UPDATE, Q_ONE, '0);
        add_sample(ACT_UPDATE, QMAX, QMAX);
        add_sample(ACT_UPDATE, QMIN, QMIN);
        add_sample(ACT_UPDATE, '0, '0);
        // undecoded index, then widest initial values
        add_reg(CFG_NONE, 32'hDEAD_BEEF);
        add_reg(CFG_INIT_EST, QMIN);
        add_reg(CFG_INIT_VAR, 32'hFFFF_FFFF);
        add_restart_checked(QMIN, 31'h7FFF_FFFF);
        // saturating gains and noise
        add_reg(CFG_STATE_GAIN, QMAX);
        add_reg(CFG_CONTROL_GAIN, QMAX);
        add_reg(CFG_MEAS_GAIN, QMIN);
        add_reg(CFG_PROCESS_VAR, 32'h7FFF_FFFF);
        add_reg(CFG_MEASURE_VAR, 32'h7FFF_FFFF);
        add_sample(ACT_UPDATE, QMAX, QMAX);
        add_sample(ACT_UPDATE, QMIN, QMIN);
        add_sample(ACT_UPDATE, '0, 32'hFFFF_FFFF);
        // H and R zero: innovation variance is zero
        add_reg(CFG_MEAS_GAIN, '0);
        add_reg(CFG_MEASURE_VAR, '0);
        add_reg(CFG_STATE_GAIN, Q_ONE);
        add_reg(CFG_CONTROL_GAIN, Q_ONE);
        add_reg(CFG_PROCESS_VAR, 32'd1678);
        add_restart_checked(QMIN, 31'h7FFF_FFFF);
        add_sample(ACT_UPDATE, 32'h0500_0000, Q_ONE);
        add_sample(ACT_UPDATE, '0, QMIN);
        // A and Q zero with unit H: predicted variance and divisor both vanish
        add_reg(CFG_MEAS_GAIN, Q_ONE);
        add_reg(CFG_STATE_GAIN, '0);
        add_reg(CFG_PROCESS_VAR, '0);
        add_sample(ACT_UPDATE, Q_ONE, '0);
        // R zero with fractional H: truncation may drive the variance negative
        add_reg(CFG_STATE_GAIN, Q_ONE);
        add_reg(CFG_MEAS_GAIN, 32'h00C0_0000);
        add_reg(CFG_INIT_EST, '0);
        add_reg(CFG_INIT_VAR, 32'h0355_5555);
        add_restart_checked('0, 31'h0355_5555);
        add_sample(ACT_UPDATE, 32'h0123_4567, '0);
        add_sample(ACT_UPDATE, 32'hFF00_0000, '0);
        add_sample(ACT_UPDATE, 32'h0000_0001, '0);
        // ordinary filter, estimate starting at the top of the range
        add_reg(CFG_MEAS_GAIN, Q_ONE);
        add_reg(CFG_CONTROL_GAIN, 32'h0080_0000);
        add_reg(CFG_PROCESS_VAR, 32'd1678);
        add_reg(CFG_MEASURE_VAR, 32'd167772);
        add_reg(CFG_INIT_EST, QMAX);
        add_reg(CFG_INIT_VAR, '0);
        add_restart_checked(QMAX, '0);
        add_sample(ACT_UPDATE, Q_ONE, Q_ONE);
        add_sample(ACT_UPDATE, 32'h0100_0001, 32'hFF80_0000);
        add_sample(ACT_UPDATE, 32'h00FF_FFFF, '0);
        add_restart_checked(QMAX, '0);
    endfunction

    // ------------------------------------------------------------ drivers

    // Hold off new items and wait until every expected result has arrived.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
    endtask

    // Leave valid high so back-to-back writes stay one transaction per edge.
    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
    endtask

    // Offer one sample in bursts with random gaps; predict it once accepted.
    task automatic offer_sample(input t_action act, input logic [31:0] z,
                                input logic [31:0] u, input bit typed,
                                input kf_result_t want);
        kf_result_t calc;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {u, z};
        do @(posedge i_clk); while (!s_axis_tready);
        calc = kalman_step(act, z, u);
        pending_updates.push_back(typed ? want : calc);
    endtask

    // Pick a register set for one random phase and write it.
    task automatic load_phase_regs(input int mode);
        logic [31:0] vals[7];
        case (mode)
            MODE_TRACK: begin
                vals[CFG_STATE_GAIN]   = around(UNITY, UNITY / 10);
                vals[CFG_MEAS_GAIN]    = around(UNITY, UNITY / 2);
                if ($urandom_range(0, 3) == 0) vals[CFG_MEAS_GAIN] = -vals[CFG_MEAS_GAIN];
                vals[CFG_CONTROL_GAIN] = around(0, UNITY / 4);
                vals[CFG_PROCESS_VAR]  = $urandom_range(0, UNITY / 64);
                vals[CFG_MEASURE_VAR]  = $urandom_range(0, 2 * UNITY);
                vals[CFG_INIT_EST]     = around(0, 4 * UNITY);
                vals[CFG_INIT_VAR]     = $urandom_range(0, 4 * UNITY);
            end
            MODE_WILD: begin
                foreach (vals[i]) vals[i] = $urandom();
            end
            MODE_EXTREME: begin
                foreach (vals[i]) vals[i] = corner_word();
            end
            default: begin
                vals[CFG_STATE_GAIN]   = around(UNITY, UNITY / 10);
                vals[CFG_MEAS_GAIN]    = $urandom_range(0, 1) ? '0 : around(0, UNITY / 4);
                vals[CFG_CONTROL_GAIN] = around(0, UNITY / 4);
                vals[CFG_PROCESS_VAR]  = $urandom_range(0, 16);
                vals[CFG_MEASURE_VAR]  = '0;
                vals[CFG_INIT_EST]     = around(0, UNITY);
                vals[CFG_INIT_VAR]     = $urandom_range(0, UNITY);
            end
        endcase
        for (int i = CFG_STATE_GAIN; i <= CFG_INIT_VAR; i++) write_reg(3'(i), vals[i]);
        if ($urandom_range(0, 2) == 0) write_reg(CFG_NONE, $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------ main sequence

    initial begin
        t_action     act;
        logic [31:0] z;
        logic [31:0] u;
        bit          reg_open;
        int          mode;

        filt_regs = '{state_gain: UNITY, meas_gain: UNITY, ctrl_gain: 0,
                      proc_var: RST_PROCESS_VAR, meas_var: RST_MEASURE_VAR,
                      init_est: 0, init_var: UNITY};
        est_q    = filt_regs.init_est;
        cov_q    = filt_regs.init_var;
        reg_open = 1'b0;
        build_directed_plan();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan; register rows only go in with nothing in flight.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                if (!reg_open) settle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
                reg_open = 1'b1;
            end else begin
                if (reg_open) i_cfg_valid <= 1'b0;
                reg_open = 1'b0;
                offer_sample(directed_rows[i].act, directed_rows[i].z, directed_rows[i].u,
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each under its own register set.
        for (int ph = 0; ph < PHASES; ph++) begin
            mode = phase_mode[ph];
            settle();
            load_phase_regs(mode);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                act = (n == 0 || $urandom_range(0, 24) == 0) ? ACT_RESTART : ACT_UPDATE;
                case (mode)
                    MODE_TRACK: begin
                        z = around(est_q, UNITY / 8);
                        u = around(0, UNITY / 2);
                    end
                    MODE_WILD: begin
                        z = $urandom();
                        u = $urandom();
                    end
                    MODE_EXTREME: begin
                        z = $urandom_range(0, 1) ? corner_word() : $urandom();
                        u = $urandom_range(0, 1) ? corner_word() : $urandom();
                    end
                    default: begin
                        z = around(est_q, UNITY);
                        u = around(0, UNITY / 4);
                    end
                endcase
                offer_sample(act, z, u, 1'b0, '0);
            end
        end

        settle();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #8_000_000;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------ receiver

    // Rotate stall styles on a free-running tick; once, hold off long enough to back up the block.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= ($urandom_range(0, 9) != 0);
                default: m_axis_tready <= (stall_tick[2:0] != 3'd0);
            endcase
        end
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick[5:0] == 6'd63) stall_style <= $urandom_range(0, 3);
    end

    // ------------------------------------------------------------ checker

    task automatic compare_field(input string what, input longint want, input longint got);
        if (want != got) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Match each result transaction against the oldest pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_r.estimate = m_axis_tdata[31:0];
            seen_r.variance = m_axis_tdata[62:32];
            seen_r.gain     = m_axis_tdata[94:63];
            seen_r.zero_div = m_axis_tuser[0];
            seen_r.clipped  = m_axis_tuser[1];
            results_seen   <= results_seen + 1;
            if (pending_updates.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got estimate %0d",
                             $time, seen_r.estimate);
                fail_count++;
            end else begin
                want_r = pending_updates.pop_front();
                compare_field("estimate_out", want_r.estimate, seen_r.estimate);
                compare_field("variance_out", want_r.variance, seen_r.variance);
                compare_field("gain_out", want_r.gain, seen_r.gain);
                compare_field("zero_divisor", want_r.zero_div, seen_r.zero_div);
                compare_field("saturated", want_r.clipped, seen_r.clipped);
            end
        end
    end

endmodule
